FILE: src/jep_pkg.sv
`default_nettype none
package jep_pkg;

    localparam int CFG_W          = 11;
    localparam int DEF_MAX_PEOPLE = 1024;

    localparam logic [CFG_W-1:0] PEOPLE_RST = 11'd7;
    localparam logic [CFG_W-1:0] STEP_RST   = 11'd3;

    // register index, taken from paddr[2]
    localparam logic REG_PEOPLE = 1'b0;
    localparam logic REG_STEP   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_CHECK,
        ST_SCAN,
        ST_PUSH
    } t_state;

endpackage
`default_nettype wire

FILE: src/jep_ram.sv
`default_nettype none
module jep_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: src/josephus_elimination_order.sv
// A request is answered once the scan has checked the circle positions from the cursor
// up to the k-th living person (dead entries and extra laps included); a none-left
// answer skips the scan. The alive map is cleared first on the first request after
// reset, restart or a register write (no clearing when n=0).
// One request at a time: the next is taken only once the result enters the output register.
// Reset (synchronous, active low) loads n=7, k=3 and marks the alive map for clearing.
`default_nettype none
module josephus_elimination_order import jep_pkg::*; #(
    parameter int MAX_PEOPLE = DEF_MAX_PEOPLE
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] restart
    // removal stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // [10:0] person
    output logic             m_tlast,   // circle emptied by this removal
    output logic             m_tuser,   // [0] none_left
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int AW = $clog2(MAX_PEOPLE);
    localparam int CW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_PEOPLE);

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_people, n_people;
    logic [CFG_W-1:0] r_step, n_step;
    logic             r_clr_pend, n_clr_pend;
    logic [AW-1:0]    r_cursor, n_cursor;
    logic [CFG_W-1:0] r_removed, n_removed;
    logic [AW-1:0]    r_clr_idx, n_clr_idx;
    logic [AW-1:0]    r_rd_pos, n_rd_pos;
    logic [AW-1:0]    r_chk_pos, n_chk_pos;
    logic             r_chk_vld, n_chk_vld;
    logic [CFG_W-1:0] r_cnt, n_cnt;
    logic [CFG_W-1:0] r_res_person, n_res_person;
    logic             r_res_last, n_res_last;
    logic             r_res_none, n_res_none;
    logic             r_ov, n_ov;
    logic [CFG_W-1:0] r_o_person, n_o_person;
    logic             r_o_last, n_o_last;
    logic             r_o_none, n_o_none;

    logic             s_acc, cfg_wr, out_free;
    logic [CW-1:0]    pc_ext, n_ext;
    logic [CFG_W-1:0] n_circ, k_eff;
    logic             restart_req, clr_done, hit, alive;
    logic             ram_we, ram_wdata;
    logic [AW-1:0]    ram_waddr;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p, input logic [CW-1:0] n);
        logic [CW-1:0] nxt;
        nxt = CW'(p) + CW'(1);
        return (nxt >= n) ? '0 : nxt[AW-1:0];
    endfunction

    assign pc_ext  = CW'(r_people);
    assign n_ext   = (pc_ext > MAX_C) ? MAX_C : pc_ext;
    assign n_circ  = n_ext[CFG_W-1:0];
    assign k_eff   = (r_step == '0) ? CFG_W'(1) : r_step;

    assign s_tready    = (r_state == ST_IDLE);
    assign s_acc       = s_tvalid && s_tready;
    assign restart_req = s_tdata[0] || r_clr_pend;
    assign cfg_wr      = psel && penable && pwrite && pready;
    assign out_free    = !r_ov || m_tready;
    assign clr_done    = (CW'(r_clr_idx) + CW'(1)) >= n_ext;
    assign hit         = r_chk_vld && alive && ((r_cnt + CFG_W'(1)) == k_eff);

    jep_ram #(
        .WIDTH (1),
        .DEPTH (MAX_PEOPLE)
    ) u_alive (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_pos),
        .o_rdata (alive)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_state = (restart_req && n_circ != '0) ? ST_CLEAR : ST_CHECK;
                end
            end
            ST_CLEAR: begin
                if (clr_done) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = (r_removed >= n_circ) ? ST_PUSH : ST_SCAN;
            end
            ST_SCAN: begin
                if (hit) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_people     = r_people;
        n_step       = r_step;
        n_clr_pend   = r_clr_pend;
        n_cursor     = r_cursor;
        n_removed    = r_removed;
        n_clr_idx    = r_clr_idx;
        n_rd_pos     = r_rd_pos;
        n_chk_pos    = r_chk_pos;
        n_chk_vld    = r_chk_vld;
        n_cnt        = r_cnt;
        n_res_person = r_res_person;
        n_res_last   = r_res_last;
        n_res_none   = r_res_none;
        n_ov         = r_ov && !m_tready;
        n_o_person   = r_o_person;
        n_o_last     = r_o_last;
        n_o_none     = r_o_none;
        ram_we       = 1'b0;
        ram_waddr    = r_clr_idx;
        ram_wdata    = 1'b1;

        unique case (r_state)
            ST_IDLE: begin
                if (s_acc && restart_req) begin
                    n_cursor   = '0;
                    n_removed  = '0;
                    n_clr_idx  = '0;
                    n_clr_pend = 1'b0;
                end
            end
            ST_CLEAR: begin
                ram_we    = 1'b1;
                n_clr_idx = r_clr_idx + AW'(1);
            end
            ST_CHECK: begin
                if (r_removed >= n_circ) begin
                    n_res_person = '0;
                    n_res_last   = 1'b0;
                    n_res_none   = 1'b1;
                end else begin
                    n_rd_pos  = r_cursor;
                    n_chk_vld = 1'b0;
                    n_cnt     = '0;
                end
            end
            ST_SCAN: begin
                // reads run one position ahead of the check
                n_rd_pos  = wrap_inc(r_rd_pos, n_ext);
                n_chk_pos = r_rd_pos;
                n_chk_vld = 1'b1;
                if (hit) begin
                    ram_we       = 1'b1;
                    ram_waddr    = r_chk_pos;
                    ram_wdata    = 1'b0;
                    n_removed    = r_removed + CFG_W'(1);
                    n_res_person = CFG_W'(CW'(r_chk_pos) + CW'(1));
                    n_res_last   = (r_removed + CFG_W'(1)) == n_circ;
                    n_res_none   = 1'b0;
                    n_cursor     = wrap_inc(r_chk_pos, n_ext);
                    n_chk_vld    = 1'b0;
                end else if (r_chk_vld && alive) begin
                    n_cnt = r_cnt + CFG_W'(1);
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    n_ov       = 1'b1;
                    n_o_person = r_res_person;
                    n_o_last   = r_res_last;
                    n_o_none   = r_res_none;
                end
            end
            default: ;
        endcase

        // any write restarts the sequence; the map is cleared on the next request
        if (cfg_wr) begin
            unique case (paddr[2])
                REG_PEOPLE: n_people = pwdata[CFG_W-1:0];
                REG_STEP:   n_step   = pwdata[CFG_W-1:0];
                default: ;
            endcase
            n_clr_pend = 1'b1;
            n_cursor   = '0;
            n_removed  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_people   <= PEOPLE_RST;
            r_step     <= STEP_RST;
            r_clr_pend <= 1'b1;
            r_cursor   <= '0;
            r_removed  <= '0;
            r_clr_idx  <= '0;
            r_chk_vld  <= 1'b0;
            r_cnt      <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_people   <= n_people;
            r_step     <= n_step;
            r_clr_pend <= n_clr_pend;
            r_cursor   <= n_cursor;
            r_removed  <= n_removed;
            r_clr_idx  <= n_clr_idx;
            r_chk_vld  <= n_chk_vld;
            r_cnt      <= n_cnt;
            r_ov       <= n_ov;
        end
        r_rd_pos     <= n_rd_pos;
        r_chk_pos    <= n_chk_pos;
        r_res_person <= n_res_person;
        r_res_last   <= n_res_last;
        r_res_none   <= n_res_none;
        r_o_person   <= n_o_person;
        r_o_last     <= n_o_last;
        r_o_none     <= n_o_none;
    end

    assign m_tvalid = r_ov;
    assign m_tdata  = {{(16 - CFG_W){1'b0}}, r_o_person};
    assign m_tlast  = r_o_last;
    assign m_tuser  = r_o_none;

    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[2])
            REG_PEOPLE: prdata = {{(32 - CFG_W){1'b0}}, r_people};
            REG_STEP:   prdata = {{(32 - CFG_W){1'b0}}, r_step};
            default:    prdata = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_removed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_removed <= n_circ)
        else $error("removal count exceeds circle size");

    a_scan_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_cnt < k_eff))
        else $error("living count overran step");

    a_none_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0 && !m_tlast))
        else $error("none-left result carries a person");

    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while busy");
`endif

endmodule
`default_nettype wire
